### src/b64se_pkg.sv
// Shared types, constants and the alphabet function of the Base64 stream encoder.
`timescale 1ns / 1ps
package b64se_pkg;

  // One group of up to three bytes, handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       brk;
    logic       last;
  } grp_t;

  // Status of the group queue as seen by both of its sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  localparam logic [7:0] LINE_GROUPS_RST = 8'd19;
  localparam logic [7:0] GIL_MAX         = 8'd255;

  // Register indexes of the configuration port.
  localparam logic REG_LINE_GROUPS = 1'b0;

  // Character positions within one group transaction sequence.
  localparam logic [2:0] CI_Q0 = 3'd0;
  localparam logic [2:0] CI_Q1 = 3'd1;
  localparam logic [2:0] CI_Q2 = 3'd2;
  localparam logic [2:0] CI_Q3 = 3'd3;
  localparam logic [2:0] CI_CR = 3'd4;
  localparam logic [2:0] CI_LF = 3'd5;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                 c = 8'h2F;
    return c;
  endfunction

endpackage

### src/b64se_front.sv
// Front end: collects bytes into groups and decides line breaks.
`timescale 1ns / 1ps
module b64se_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_last_byte,
  input  logic [7:0]         line_groups,
  output logic               grp_push,
  output b64se_pkg::grp_t    grp
);
  import b64se_pkg::*;

  logic [15:0] pend_bytes_r, pend_bytes_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [7:0]  gil_r, gil_nxt;
  logic [1:0]  cnt;
  logic [7:0]  gil_inc;
  logic        hold;
  logic        brk;

  always_comb begin
    cnt     = (pend_cnt_r == 2'd3) ? 2'd2 : pend_cnt_r;
    hold    = !in_last_byte && (cnt < 2'd2);
    gil_inc = (gil_r == GIL_MAX) ? GIL_MAX : gil_r + 8'd1;
    brk     = (line_groups != 8'd0) && (gil_inc >= line_groups);

    grp.b0     = (cnt == 2'd0) ? in_byte : pend_bytes_r[15:8];
    grp.b1     = (cnt == 2'd2) ? pend_bytes_r[7:0] : ((cnt == 2'd1) ? in_byte : 8'd0);
    grp.b2     = (cnt == 2'd2) ? in_byte : 8'd0;
    grp.nbytes = cnt + 2'd1;
    grp.brk    = brk;
    grp.last   = in_last_byte;
    grp_push   = accept && !hold;

    pend_bytes_nxt = pend_bytes_r;
    pend_cnt_nxt   = pend_cnt_r;
    gil_nxt        = gil_r;
    if (accept) begin
      if (hold) begin
        if (cnt == 2'd0) pend_bytes_nxt = {in_byte, 8'd0};
        else             pend_bytes_nxt = {pend_bytes_r[15:8], in_byte};
        pend_cnt_nxt = cnt + 2'd1;
      end else begin
        pend_bytes_nxt = 16'd0;
        pend_cnt_nxt   = 2'd0;
        gil_nxt        = (brk || in_last_byte) ? 8'd0 : gil_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_bytes_r <= pend_bytes_nxt;
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      gil_r      <= 8'd0;
    end else begin
      pend_cnt_r <= pend_cnt_nxt;
      gil_r      <= gil_nxt;
    end
  end

endmodule

### src/b64se_fifo.sv
// Short queue of groups between the front end and the back end.
`timescale 1ns / 1ps
module b64se_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64se_pkg::grp_t    wr_grp,
  input  logic               pop,
  output b64se_pkg::grp_t    rd_grp,
  output b64se_pkg::q_stat_t stat
);
  import b64se_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  grp_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == FULL_CNT);
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    rd_grp     = mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_grp;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### src/b64se_back.sv
// Back end: queued groups to characters in the output register, one per cycle if popped.
`timescale 1ns / 1ps
module b64se_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b64se_pkg::grp_t    grp,
  input  logic               grp_avail,
  output logic               grp_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_char,
  output logic               out_last_char
);
  import b64se_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] char_r, char_nxt;
  logic       lastc_r, lastc_nxt;
  logic       load;
  logic       final_char;
  logic [7:0] ch;

  always_comb begin
    unique case (idx_r)
      CI_Q0: ch = b64_char(grp.b0[7:2]);
      CI_Q1: ch = b64_char({grp.b0[1:0], grp.b1[7:4]});
      CI_Q2: ch = (grp.nbytes < 2'd2) ? CHAR_PAD : b64_char({grp.b1[3:0], grp.b2[7:6]});
      CI_Q3: ch = (grp.nbytes < 2'd3) ? CHAR_PAD : b64_char(grp.b2[5:0]);
      CI_CR: ch = CHAR_CR;
      CI_LF: ch = CHAR_LF;
      default: ch = CHAR_LF;
    endcase

    final_char = ((idx_r == CI_Q3) && !grp.brk) || (idx_r == CI_LF);
    load       = (!vld_r || pop) && grp_avail;
    grp_pop    = load && final_char;

    vld_nxt   = vld_r;
    char_nxt  = char_r;
    lastc_nxt = lastc_r;
    idx_nxt   = idx_r;
    if (vld_r && pop) vld_nxt = 1'b0;
    if (load) begin
      vld_nxt   = 1'b1;
      char_nxt  = ch;
      lastc_nxt = grp.last && final_char;
      idx_nxt   = final_char ? CI_Q0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    lastc_r <= lastc_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= CI_Q0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign empty         = !vld_r;
  assign out_char      = char_r;
  assign out_last_char = lastc_r;

endmodule

### src/base64_stream_encoder.sv
// Top level of the Base64 stream encoder with line wrapping and its register port.
// A group goes into the group queue, then its first character into the output register.
// One character is emitted per cycle while results are popped: 4 per group of three bytes, or
// 6 with a CR LF break. Bytes are taken one per cycle until the group queue fills.
// Reset (rst_n low, synchronous) empties the queue and output register, drops the held bytes
// and clears the line count, and sets line_groups to 19.
`timescale 1ns / 1ps
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  // Result queue side
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_char,
  output logic        out_last_char,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64se_pkg::*;

  logic       accept;
  logic       grp_push;
  logic       grp_pop;
  grp_t       wr_grp;
  grp_t       rd_grp;
  q_stat_t    q_stat;
  logic [7:0] line_groups_r, line_groups_nxt;
  logic       reg_sel;

  // Register port: one register, line_groups, at byte address 0. The word index is
  // paddr[2]; the low address bits are ignored. Writes elsewhere are dropped.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_LINE_GROUPS);

  always_comb begin
    line_groups_nxt = line_groups_r;
    if (psel && penable && pwrite && pready && reg_sel) line_groups_nxt = pwdata[7:0];
    prdata = reg_sel ? {24'd0, line_groups_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) line_groups_r <= LINE_GROUPS_RST;
    else        line_groups_r <= line_groups_nxt;
  end

  // A byte transaction is taken whenever the group queue has room, even when the
  // byte is only held; this keeps full free of any dependence on the byte itself.
  assign full   = q_stat.full;
  assign accept = push && !full;

  // The front end groups bytes and decides the CR LF break at group time, so the
  // queue carries everything the back end needs to emit one group.
  b64se_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .line_groups  (line_groups_r),
    .grp_push     (grp_push),
    .grp          (wr_grp)
  );

  b64se_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (grp_push),
    .wr_grp (wr_grp),
    .pop    (grp_pop),
    .rd_grp (rd_grp),
    .stat   (q_stat)
  );

  // The back end walks the head group one character per cycle while results are popped, and
  // retires it from the queue as its final character is loaded into the output register.
  b64se_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .grp           (rd_grp),
    .grp_avail     (!q_stat.empty),
    .grp_pop       (grp_pop),
    .pop           (pop),
    .empty         (empty),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

### src/b64se_checker.sv
// Port-level checks of the Base64 stream encoder and their binding to the top level.
`timescale 1ns / 1ps
module b64se_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [7:0]  out_char,
  input logic        out_last_char
);
  import b64se_pkg::*;

  // Reset leaves both queue sides idle.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("encoder not idle after reset");

  // A CR is always followed at once by its LF.
  a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_char == CHAR_CR) |=> (!empty && out_char == CHAR_LF))
    else $error("CR not followed by LF");

  // A message never ends on a CR.
  a_last_not_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_char) |-> (out_char != CHAR_CR))
    else $error("message ends on CR");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(out_last_char)))
    else $error("waiting result changed");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (.*);
